// ----- rtl/tlc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared constants and types of the two-level write-back cache model.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int NEAR_SETS_DEF  = 64;
    localparam int FAR_SETS_DEF   = 512;
    localparam int WAYS_DEF       = 8;
    localparam int LINE_SHIFT_DEF = 6;

    localparam int ADDR_W = 64;
    localparam int CNT_W  = 32;
    localparam int WB_W   = 2;
    localparam int OUT_W  = 232;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_stat;

endpackage

// ----- rtl/tlc_front.sv -----
// ----------------------------------------------------------------------------
// tlc_front
// Accepts accesses, derives line number and set indexes, and queues them.
// ----------------------------------------------------------------------------
module tlc_front #(
    parameter int NEAR_SETS  = 64,
    parameter int FAR_SETS   = 512,
    parameter int LINE_SHIFT = 6
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    input  logic [tlc_pkg::ADDR_W-1:0]                 i_s_tdata,
    input  logic                                       i_s_tuser,
    input  tlc_pkg::t_back_stat                        i_stat,
    output logic                                       o_q_valid,
    output logic [tlc_pkg::ADDR_W-LINE_SHIFT-1:0]      o_q_line,
    output logic                                       o_q_wr,
    output logic [$clog2(NEAR_SETS)-1:0]               o_q_ns,
    output logic [$clog2(FAR_SETS)-1:0]                o_q_fs
);
    import tlc_pkg::*;

    localparam int LW     = ADDR_W - LINE_SHIFT;
    localparam int NI     = $clog2(NEAR_SETS);
    localparam int FI     = $clog2(FAR_SETS);
    localparam bit SERIAL = !((NEAR_SETS == (1 << NI)) && (FAR_SETS == (1 << FI)));
    localparam int STEPS  = 4;
    localparam int NCYC   = (LW + STEPS - 1) / STEPS;
    localparam int PW     = NCYC * STEPS;
    localparam int KW     = $clog2(NCYC);
    localparam logic [NI:0] NS_C = (NI+1)'(NEAR_SETS);
    localparam logic [FI:0] FS_C = (FI+1)'(FAR_SETS);

    logic [LW-1:0] r_q_line [2];
    logic          r_q_wr   [2];
    logic [NI-1:0] r_q_ns   [2];
    logic [FI-1:0] r_q_fs   [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    logic          r_busy, r_hold, r_wr;
    logic [KW-1:0] r_k;
    logic [PW-1:0] r_sh;
    logic [LW-1:0] r_line;
    logic [NI-1:0] r_nr;
    logic [FI-1:0] r_fr;

    logic          s_acc, push, pop, full;
    logic [LW-1:0] a_line, p_line;
    logic          p_wr;
    logic [NI-1:0] p_ns, n_nr;
    logic [FI-1:0] p_fs, n_fr;
    logic [NI:0]   t_n;
    logic [FI:0]   t_f;

    assign full   = (r_cnt == 2'd2);
    assign a_line = i_s_tdata[ADDR_W-1:LINE_SHIFT];
    assign o_s_tready = SERIAL ? (!i_stat.clearing && !r_busy && !r_hold)
                               : (!i_stat.clearing && !full);
    assign s_acc  = i_s_tvalid && o_s_tready;
    assign pop    = i_stat.pop && (r_cnt != 2'd0);
    assign push   = SERIAL ? (r_hold && !full) : s_acc;
    assign p_line = SERIAL ? r_line : a_line;
    assign p_wr   = SERIAL ? r_wr : i_s_tuser;
    assign p_ns   = SERIAL ? r_nr : a_line[NI-1:0];
    assign p_fs   = SERIAL ? r_fr : a_line[FI-1:0];

    always_comb begin
        n_nr = r_nr;
        n_fr = r_fr;
        t_n  = '0;
        t_f  = '0;
        for (int s = 0; s < STEPS; s++) begin
            t_n = {n_nr, r_sh[PW-1-s]};
            if (t_n >= NS_C) t_n = t_n - NS_C;
            n_nr = t_n[NI-1:0];
            t_f = {n_fr, r_sh[PW-1-s]};
            if (t_f >= FS_C) t_f = t_f - FS_C;
            n_fr = t_f[FI-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_hold <= 1'b0;
            r_k    <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (SERIAL) begin
                if (s_acc) begin
                    r_busy <= 1'b1;
                    r_k    <= '0;
                    r_sh   <= PW'(a_line);
                    r_line <= a_line;
                    r_wr   <= i_s_tuser;
                    r_nr   <= '0;
                    r_fr   <= '0;
                end else if (r_busy) begin
                    r_nr <= n_nr;
                    r_fr <= n_fr;
                    r_sh <= r_sh << STEPS;
                    r_k  <= r_k + 1'b1;
                    if (r_k == KW'(NCYC - 1)) begin
                        r_busy <= 1'b0;
                        r_hold <= 1'b1;
                    end
                end else if (push) begin
                    r_hold <= 1'b0;
                end
            end
            if (push) begin
                r_q_line[r_wp] <= p_line;
                r_q_wr[r_wp]   <= p_wr;
                r_q_ns[r_wp]   <= p_ns;
                r_q_fs[r_wp]   <= p_fs;
                r_wp           <= !r_wp;
            end
            if (pop) r_rp <= !r_rp;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_line  = r_q_line[r_rp];
    assign o_q_wr    = r_q_wr[r_rp];
    assign o_q_ns    = r_q_ns[r_rp];
    assign o_q_fs    = r_q_fs[r_rp];

endmodule

// ----- rtl/tlc_back.sv -----
// ----------------------------------------------------------------------------
// tlc_back
// Carries out queued accesses against the two tag memories and keeps totals.
// ----------------------------------------------------------------------------
module tlc_back #(
    parameter int NEAR_SETS  = 64,
    parameter int FAR_SETS   = 512,
    parameter int WAYS       = 8,
    parameter int LINE_SHIFT = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    input  logic [tlc_pkg::ADDR_W-LINE_SHIFT-1:0] i_q_line,
    input  logic                                  i_q_wr,
    input  logic [$clog2(NEAR_SETS)-1:0]          i_q_ns,
    input  logic [$clog2(FAR_SETS)-1:0]           i_q_fs,
    output tlc_pkg::t_back_stat                   o_stat,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [tlc_pkg::OUT_W-1:0]             o_m_tdata
);
    import tlc_pkg::*;

    localparam int LW   = ADDR_W - LINE_SHIFT;
    localparam int NI   = $clog2(NEAR_SETS);
    localparam int FI   = $clog2(FAR_SETS);
    localparam int RW   = $clog2(WAYS);
    localparam int MAXS = (NEAR_SETS > FAR_SETS) ? NEAR_SETS : FAR_SETS;
    localparam int CW   = $clog2(MAXS);

    typedef logic [WAYS-1:0][RW-1:0] t_rks;
    typedef struct packed {
        logic          v;
        logic          d;
        logic [FI-1:0] fs;
        logic [LW-1:0] tag;
    } t_nway;
    typedef struct packed {
        logic          v;
        logic          d;
        logic [LW-1:0] tag;
    } t_fway;
    typedef struct packed {
        t_nway [WAYS-1:0] w;
        t_rks             rk;
    } t_nrow;
    typedef struct packed {
        t_fway [WAYS-1:0] w;
        t_rks             rk;
    } t_frow;

    typedef enum logic [2:0] {S_CLR, S_FETCH, S_LOOK, S_EVRD, S_EV, S_OUT} t_state;

    function automatic t_rks touch(t_rks rk, logic [RW-1:0] way);
        t_rks        r;
        logic [RW-1:0] old;
        r   = rk;
        old = rk[way];
        for (int k = 0; k < WAYS; k++) begin
            if (rk[k] > old) r[k] = rk[k] - 1'b1;
        end
        r[way] = RW'(WAYS - 1);
        return r;
    endfunction

    function automatic logic [RW-1:0] victim(t_rks rk);
        logic [RW-1:0] v;
        logic          f;
        v = '0;
        f = 1'b0;
        for (int k = 0; k < WAYS; k++) begin
            if (!f && rk[k] == '0) begin
                v = RW'(k);
                f = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic t_rks rk_init();
        t_rks r;
        for (int k = 0; k < WAYS; k++) r[k] = RW'(k);
        return r;
    endfunction

    t_nrow near_mem [NEAR_SETS];
    t_frow far_mem  [FAR_SETS];

    t_state        r_state, n_state;
    logic [CW-1:0] r_clr, n_clr;
    t_nrow         r_nrd;
    t_frow         r_frd;
    logic [LW-1:0] r_line, n_line, r_ev_line, n_ev_line;
    logic          r_wr, n_wr;
    logic [NI-1:0] r_ns, n_ns;
    logic [FI-1:0] r_fs, n_fs, r_ev_fs, n_ev_fs;
    logic          r_h1, n_h1, r_h2, n_h2;
    logic [WB_W-1:0] r_wb, n_wb;
    logic          r_ovalid, n_ovalid;
    logic          r_o_h1, n_o_h1, r_o_h2, n_o_h2;
    logic [WB_W-1:0] r_o_wb, n_o_wb;
    logic [CNT_W-1:0] r_c_wr, r_c_rd, r_c_h1, r_c_m1, r_c_h2, r_c_m2, r_c_wb;
    logic [CNT_W-1:0] n_c_wr, n_c_rd, n_c_h1, n_c_m1, n_c_h2, n_c_m2, n_c_wb;

    logic          nm_we, nm_re, fm_we, fm_re;
    logic [NI-1:0] nm_wa, nm_ra;
    logic [FI-1:0] fm_wa, fm_ra;
    t_nrow         nm_wd;
    t_frow         fm_wd;

    logic          hit, fhit, pop;
    logic [RW-1:0] wsel, fsel, vsel;
    t_nrow         nrow;
    t_frow         frow;
    t_nway         ev;

    always_ff @(posedge i_clk) begin
        if (nm_we) near_mem[nm_wa] <= nm_wd;
        if (nm_re) r_nrd <= near_mem[nm_ra];
        if (fm_we) far_mem[fm_wa] <= fm_wd;
        if (fm_re) r_frd <= far_mem[fm_ra];
    end

    always_comb begin
        n_state = r_state;   n_clr = r_clr;
        n_line = r_line;     n_wr = r_wr;     n_ns = r_ns;   n_fs = r_fs;
        n_ev_line = r_ev_line; n_ev_fs = r_ev_fs;
        n_h1 = r_h1;         n_h2 = r_h2;     n_wb = r_wb;
        n_ovalid = r_ovalid && !i_m_tready;
        n_o_h1 = r_o_h1;     n_o_h2 = r_o_h2; n_o_wb = r_o_wb;
        n_c_wr = r_c_wr;     n_c_rd = r_c_rd; n_c_h1 = r_c_h1; n_c_m1 = r_c_m1;
        n_c_h2 = r_c_h2;     n_c_m2 = r_c_m2; n_c_wb = r_c_wb;
        nm_we = 1'b0; nm_re = 1'b0; fm_we = 1'b0; fm_re = 1'b0;
        nm_wa = r_ns; nm_ra = i_q_ns; fm_wa = r_fs; fm_ra = i_q_fs;
        nm_wd = r_nrd; fm_wd = r_frd;
        pop = 1'b0;
        nrow = r_nrd; frow = r_frd;
        hit = 1'b0; wsel = '0; fhit = 1'b0; fsel = '0; vsel = '0; ev = '0;

        unique case (r_state)
            S_CLR: begin
                nm_wd    = '0;
                nm_wd.rk = rk_init();
                fm_wd    = '0;
                fm_wd.rk = rk_init();
                nm_wa    = r_clr[NI-1:0];
                fm_wa    = r_clr[FI-1:0];
                nm_we    = ({1'b0, r_clr} < (CW+1)'(NEAR_SETS));
                fm_we    = ({1'b0, r_clr} < (CW+1)'(FAR_SETS));
                n_clr    = r_clr + 1'b1;
                if (r_clr == CW'(MAXS - 1)) n_state = S_FETCH;
            end
            S_FETCH: begin
                if (i_q_valid) begin
                    pop    = 1'b1;
                    nm_re  = 1'b1;
                    fm_re  = 1'b1;
                    n_line = i_q_line;
                    n_wr   = i_q_wr;
                    n_ns   = i_q_ns;
                    n_fs   = i_q_fs;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                for (int k = 0; k < WAYS; k++) begin
                    if (!hit && nrow.w[k].v && nrow.w[k].tag == r_line) begin
                        hit  = 1'b1;
                        wsel = RW'(k);
                    end
                end
                n_h1 = hit;
                n_h2 = 1'b0;
                n_wb = '0;
                nm_we = 1'b1;
                if (hit) begin
                    nrow.rk = touch(nrow.rk, wsel);
                    if (r_wr) nrow.w[wsel].d = 1'b1;
                    n_state = S_OUT;
                end else begin
                    vsel = victim(nrow.rk);
                    ev   = nrow.w[vsel];
                    for (int k = 0; k < WAYS; k++) begin
                        if (!fhit && frow.w[k].v && frow.w[k].tag == r_line) begin
                            fhit = 1'b1;
                            fsel = RW'(k);
                        end
                    end
                    n_h2 = fhit;
                    if (fhit) begin
                        frow.rk = touch(frow.rk, fsel);
                    end else begin
                        fsel = victim(frow.rk);
                        n_wb = {1'b0, frow.w[fsel].v && frow.w[fsel].d};
                        frow.w[fsel] = '{v: 1'b1, d: 1'b0, tag: r_line};
                        frow.rk = touch(frow.rk, fsel);
                    end
                    fm_we = 1'b1;
                    nrow.w[vsel] = '{v: 1'b1, d: r_wr, fs: r_fs, tag: r_line};
                    nrow.rk = touch(nrow.rk, vsel);
                    n_ev_line = ev.tag;
                    n_ev_fs   = ev.fs;
                    n_state   = (ev.v && ev.d) ? S_EVRD : S_OUT;
                end
                nm_wd = nrow;
                fm_wd = frow;
            end
            S_EVRD: begin
                fm_re   = 1'b1;
                fm_ra   = r_ev_fs;
                n_state = S_EV;
            end
            S_EV: begin
                for (int k = 0; k < WAYS; k++) begin
                    if (!fhit && frow.w[k].v && frow.w[k].tag == r_ev_line) begin
                        fhit = 1'b1;
                        fsel = RW'(k);
                    end
                end
                if (fhit) begin
                    frow.w[fsel].d = 1'b1;
                end else begin
                    fsel = victim(frow.rk);
                    n_wb = r_wb + WB_W'(frow.w[fsel].v && frow.w[fsel].d);
                    frow.w[fsel] = '{v: 1'b1, d: 1'b1, tag: r_ev_line};
                    frow.rk = touch(frow.rk, fsel);
                end
                fm_we   = 1'b1;
                fm_wa   = r_ev_fs;
                fm_wd   = frow;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_o_h1   = r_h1;
                    n_o_h2   = r_h2;
                    n_o_wb   = r_wb;
                    if (r_wr) n_c_wr = r_c_wr + 1'b1;
                    else      n_c_rd = r_c_rd + 1'b1;
                    if (r_h1) n_c_h1 = r_c_h1 + 1'b1;
                    else      n_c_m1 = r_c_m1 + 1'b1;
                    if (!r_h1 && r_h2)  n_c_h2 = r_c_h2 + 1'b1;
                    if (!r_h1 && !r_h2) n_c_m2 = r_c_m2 + 1'b1;
                    n_c_wb  = r_c_wb + CNT_W'(r_wb);
                    n_state = S_FETCH;
                end
            end
            default: n_state = S_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_c_wr <= '0; r_c_rd <= '0; r_c_h1 <= '0; r_c_m1 <= '0;
            r_c_h2 <= '0; r_c_m2 <= '0; r_c_wb <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_c_wr <= n_c_wr; r_c_rd <= n_c_rd; r_c_h1 <= n_c_h1; r_c_m1 <= n_c_m1;
            r_c_h2 <= n_c_h2; r_c_m2 <= n_c_m2; r_c_wb <= n_c_wb;
        end
        r_line <= n_line;  r_wr <= n_wr;  r_ns <= n_ns;  r_fs <= n_fs;
        r_ev_line <= n_ev_line;  r_ev_fs <= n_ev_fs;
        r_h1 <= n_h1;  r_h2 <= n_h2;  r_wb <= n_wb;
        r_o_h1 <= n_o_h1;  r_o_h2 <= n_o_h2;  r_o_wb <= n_o_wb;
    end

    assign o_stat.pop      = pop;
    assign o_stat.clearing = (r_state == S_CLR);
    assign o_m_tvalid      = r_ovalid;
    assign o_m_tdata = {4'b0, r_c_wb, r_c_m2, r_c_h2, r_c_m1, r_c_h1, r_c_rd, r_c_wr,
                        r_o_wb, r_o_h2, r_o_h1};

endmodule

// ----- rtl/two_level_lru_writeback_cache_model.sv -----
// ----------------------------------------------------------------------------
// two_level_lru_writeback_cache_model
// Two-level set-associative LRU write-back cache model with running totals.
// ----------------------------------------------------------------------------
// Each access yields one result. After reset a clearing pass over
// max(NEAR_SETS, FAR_SETS) rows (512 by default) initializes both tag
// memories, and no access is taken meanwhile. In the back end a first-level
// hit or a plain miss goes through the fetch, lookup and output states, and
// a miss whose first-level victim is dirty adds an eviction read and an
// eviction write of the far tag memory before the output state. With set
// counts that are not powers of two the front end derives set indexes four
// address bits per cycle and takes no new access until the last is queued.
module two_level_lru_writeback_cache_model #(
    parameter int NEAR_SETS  = tlc_pkg::NEAR_SETS_DEF,
    parameter int FAR_SETS   = tlc_pkg::FAR_SETS_DEF,
    parameter int WAYS       = tlc_pkg::WAYS_DEF,
    parameter int LINE_SHIFT = tlc_pkg::LINE_SHIFT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [tlc_pkg::ADDR_W-1:0] i_s_tdata,  // address
    input  logic                      i_s_tuser,  // store flag
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // l1_hit, l2_hit, writebacks[2], total_writes, total_reads, total_l1_hits,
    // total_l1_misses, total_l2_hits, total_l2_misses, total_writebacks
    output logic [tlc_pkg::OUT_W-1:0]  o_m_tdata
);
    import tlc_pkg::*;

    t_back_stat                       stat;
    logic                             q_valid, q_wr;
    logic [ADDR_W-LINE_SHIFT-1:0]     q_line;
    logic [$clog2(NEAR_SETS)-1:0]     q_ns;
    logic [$clog2(FAR_SETS)-1:0]      q_fs;

    tlc_front #(
        .NEAR_SETS(NEAR_SETS), .FAR_SETS(FAR_SETS), .LINE_SHIFT(LINE_SHIFT)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_stat(stat),
        .o_q_valid(q_valid), .o_q_line(q_line), .o_q_wr(q_wr),
        .o_q_ns(q_ns), .o_q_fs(q_fs)
    );

    tlc_back #(
        .NEAR_SETS(NEAR_SETS), .FAR_SETS(FAR_SETS), .WAYS(WAYS),
        .LINE_SHIFT(LINE_SHIFT)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_line(q_line), .i_q_wr(q_wr),
        .i_q_ns(q_ns), .i_q_fs(q_fs),
        .o_stat(stat),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

endmodule

// ----- dv/two_level_lru_writeback_cache_model_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_lru_writeback_cache_model_tb
// Self-checking bench for the two-level write-back cache model. A directed
// table and then random loads and stores drive the input stream. An in-bench
// model of both cache levels predicts each output transaction, and every
// field is compared in order of arrival.
// ----------------------------------------------------------------------------
module two_level_lru_writeback_cache_model_tb;

    import tlc_pkg::*;

    localparam int NSETS = 64;
    localparam int FSETS = 512;
    localparam int NWAYS = 8;
    localparam int LSH   = 6;

    typedef struct packed {
        logic [CNT_W-1:0] wbk_tot;
        logic [CNT_W-1:0] l2m_tot;
        logic [CNT_W-1:0] l2h_tot;
        logic [CNT_W-1:0] l1m_tot;
        logic [CNT_W-1:0] l1h_tot;
        logic [CNT_W-1:0] rd_tot;
        logic [CNT_W-1:0] wr_tot;
        logic [WB_W-1:0]  wbk;
        logic             l2h;
        logic             l1h;
    } t_access_res;

    typedef struct {
        logic [63:0] addr;
        logic        wr;
        logic        chk;
        logic        l1h;
        logic        l2h;
        logic [1:0]  wbk;
    } t_access_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [ADDR_W-1:0]     i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_W-1:0]      o_m_tdata;

    two_level_lru_writeback_cache_model u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // address
        .i_s_tuser  (i_s_tuser),   // store flag
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)    // l1_hit, l2_hit, writebacks, totals
    );

    logic [57:0] n_tag [NSETS*NWAYS];
    logic        n_val [NSETS*NWAYS];
    logic        n_drt [NSETS*NWAYS];
    logic [2:0]  n_rnk [NSETS*NWAYS];
    logic [57:0] f_tag [FSETS*NWAYS];
    logic        f_val [FSETS*NWAYS];
    logic        f_drt [FSETS*NWAYS];
    logic [2:0]  f_rnk [FSETS*NWAYS];
    logic [CNT_W-1:0] c_wr, c_rd, c_l1h, c_l1m, c_l2h, c_l2m, c_wbk;

    t_access_res pending_res[$];
    int          errors = 0;
    int          send_idle = 0;
    int          recv_idle = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void lru_touch_near(int base, int way);
        logic [2:0] old;
        old = n_rnk[base + way];
        for (int k = 0; k < NWAYS; k++) begin
            if (n_rnk[base + k] > old) n_rnk[base + k]--;
        end
        n_rnk[base + way] = 3'(NWAYS - 1);
    endfunction

    function automatic void lru_touch_far(int base, int way);
        logic [2:0] old;
        old = f_rnk[base + way];
        for (int k = 0; k < NWAYS; k++) begin
            if (f_rnk[base + k] > old) f_rnk[base + k]--;
        end
        f_rnk[base + way] = 3'(NWAYS - 1);
    endfunction

    function automatic int far_victim(int base);
        for (int k = 0; k < NWAYS; k++) begin
            if (f_rnk[base + k] == 0) return k;
        end
        return 0;
    endfunction

    function automatic int near_victim(int base);
        for (int k = 0; k < NWAYS; k++) begin
            if (n_rnk[base + k] == 0) return k;
        end
        return 0;
    endfunction

    function automatic int far_find(logic [57:0] ln);
        int base;
        base = int'(ln % FSETS) * NWAYS;
        for (int k = 0; k < NWAYS; k++) begin
            if (f_val[base + k] && f_tag[base + k] == ln) return k;
        end
        return NWAYS;
    endfunction

    function automatic int far_place(logic [57:0] ln, logic drt);
        int base, v, wb;
        base = int'(ln % FSETS) * NWAYS;
        v = far_victim(base);
        wb = (f_val[base + v] && f_drt[base + v]) ? 1 : 0;
        f_tag[base + v] = ln;
        f_val[base + v] = 1'b1;
        f_drt[base + v] = drt;
        lru_touch_far(base, v);
        return wb;
    endfunction

    function automatic void cache_clear();
        for (int i = 0; i < NSETS*NWAYS; i++) begin
            n_tag[i] = '0; n_val[i] = 1'b0; n_drt[i] = 1'b0; n_rnk[i] = 3'(i % NWAYS);
        end
        for (int i = 0; i < FSETS*NWAYS; i++) begin
            f_tag[i] = '0; f_val[i] = 1'b0; f_drt[i] = 1'b0; f_rnk[i] = 3'(i % NWAYS);
        end
        {c_wr, c_rd, c_l1h, c_l1m, c_l2h, c_l2m, c_wbk} = '0;
    endfunction

    function automatic t_access_res cache_access(logic [63:0] addr, logic wr);
        t_access_res r;
        logic [57:0] ln;
        int nb, fb, w, v, f, wbs, vb;
        ln = 58'(addr >> LSH);
        nb = int'(ln % NSETS) * NWAYS;
        fb = int'(ln % FSETS) * NWAYS;
        wbs = 0;
        r = '0;
        if (wr) c_wr++;
        else c_rd++;
        w = NWAYS;
        for (int k = NWAYS - 1; k >= 0; k--) begin
            if (n_val[nb + k] && n_tag[nb + k] == ln) w = k;
        end
        if (w < NWAYS) begin
            r.l1h = 1'b1;
            c_l1h++;
            lru_touch_near(nb, w);
            if (wr) n_drt[nb + w] = 1'b1;
        end else begin
            c_l1m++;
            v = near_victim(nb);
            f = far_find(ln);
            if (f < NWAYS) begin
                r.l2h = 1'b1;
                c_l2h++;
                lru_touch_far(fb, f);
            end else begin
                c_l2m++;
                wbs += far_place(ln, 1'b0);
            end
            if (n_val[nb + v] && n_drt[nb + v]) begin
                f = far_find(n_tag[nb + v]);
                vb = int'(n_tag[nb + v] % FSETS) * NWAYS;
                if (f < NWAYS) f_drt[vb + f] = 1'b1;
                else wbs += far_place(n_tag[nb + v], 1'b1);
            end
            n_tag[nb + v] = ln;
            n_val[nb + v] = 1'b1;
            n_drt[nb + v] = wr;
            lru_touch_near(nb, v);
        end
        c_wbk = c_wbk + CNT_W'(wbs);
        r.wbk = wbs[1:0];
        r.wr_tot = c_wr; r.rd_tot = c_rd; r.l1h_tot = c_l1h; r.l1m_tot = c_l1m;
        r.l2h_tot = c_l2h; r.l2m_tot = c_l2m; r.wbk_tot = c_wbk;
        return r;
    endfunction

    task automatic send_access(logic [63:0] addr, logic wr);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= addr;
        i_s_tuser  <= wr;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_res.push_back(cache_access(addr, wr));
    endtask

    // Random address; most draws narrow the upper bits or the set so that lines repeat and evictions chain up.
    function automatic logic [63:0] rand_addr();
        logic [63:0] a;
        a = {$urandom, $urandom};
        case ($urandom_range(3))
            0: a[63:LSH+12] = 46'($urandom_range(15));
            1: begin
                a[63:LSH+12] = 46'($urandom_range(3));
                a[LSH+8:LSH] = 9'($urandom_range(3) * 64);
            end
            2: a[63:LSH+9] = 49'($urandom_range(40));
            default: ;
        endcase
        return a;
    endfunction

    initial begin
        t_access_row rows[$];
        t_access_res got, exp_res;
        int wait_cnt;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        i_m_tready = 1'b0;
        cache_clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back('{64'h0, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0});
        rows.push_back('{64'h3F, 1'b1, 1'b1, 1'b1, 1'b0, 2'd0});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 2'd0});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFC0, 1'b0, 1'b1, 1'b1, 1'b0, 2'd0});
        for (int i = 1; i <= 9; i++) begin
            rows.push_back('{64'(i) << (LSH + 9), 1'b1, 1'b0, 1'b0, 1'b0, 2'd0});
        end
        rows.push_back('{64'h0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0});
        for (int i = 10; i <= 18; i++) begin
            rows.push_back('{64'(i) << (LSH + 9), 1'b0, 1'b0, 1'b0, 1'b0, 2'd0});
        end
        rows.push_back('{64'h5555_AAAA_5555_AAAA, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0});
        rows.push_back('{64'hAAAA_5555_AAAA_5555, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0});

        fork
            begin
                foreach (rows[i]) begin
                    if (rows[i].chk) begin
                        exp_res = cache_access(rows[i].addr, rows[i].wr);
                        if (exp_res.l1h !== rows[i].l1h || exp_res.l2h !== rows[i].l2h
                            || exp_res.wbk !== rows[i].wbk) begin
                            $error("table row %0d disagrees with bench model", i);
                            errors++;
                        end
                        cache_clear();
                        for (int j = 0; j < i; j++) begin
                            void'(cache_access(rows[j].addr, rows[j].wr));
                        end
                    end
                    send_access(rows[i].addr, rows[i].wr);
                end
                for (int ph = 0; ph < 3; ph++) begin
                    send_idle = (ph == 0) ? 11 : (ph == 1) ? 84 : 0;
                    recv_idle = (ph == 0) ? 84 : (ph == 1) ? 11 : 0;
                    for (int n = 0; n < 375; n++) begin
                        send_access(rand_addr(), 1'($urandom));
                    end
                end
                i_s_tvalid <= 1'b0;
            end
            forever begin
                i_m_tready <= ($urandom_range(99) >= recv_idle);
                @(posedge i_clk);
                if (o_m_tvalid && i_m_tready) begin
                    got = o_m_tdata[$bits(t_access_res)-1:0];
                    if (pending_res.size() == 0) begin
                        $error("unexpected output transaction");
                        errors++;
                    end else begin
                        exp_res = pending_res.pop_front();
                        if (got.l1h !== exp_res.l1h)
                            $error("l1_hit exp %0h got %0h", exp_res.l1h, got.l1h);
                        if (got.l2h !== exp_res.l2h)
                            $error("l2_hit exp %0h got %0h", exp_res.l2h, got.l2h);
                        if (got.wbk !== exp_res.wbk)
                            $error("writebacks exp %0h got %0h", exp_res.wbk, got.wbk);
                        if (got.wr_tot !== exp_res.wr_tot)
                            $error("total_writes exp %0h got %0h", exp_res.wr_tot, got.wr_tot);
                        if (got.rd_tot !== exp_res.rd_tot)
                            $error("total_reads exp %0h got %0h", exp_res.rd_tot, got.rd_tot);
                        if (got.l1h_tot !== exp_res.l1h_tot)
                            $error("total_l1_hits exp %0h got %0h",
                                   exp_res.l1h_tot, got.l1h_tot);
                        if (got.l1m_tot !== exp_res.l1m_tot)
                            $error("total_l1_misses exp %0h got %0h",
                                   exp_res.l1m_tot, got.l1m_tot);
                        if (got.l2h_tot !== exp_res.l2h_tot)
                            $error("total_l2_hits exp %0h got %0h",
                                   exp_res.l2h_tot, got.l2h_tot);
                        if (got.l2m_tot !== exp_res.l2m_tot)
                            $error("total_l2_misses exp %0h got %0h",
                                   exp_res.l2m_tot, got.l2m_tot);
                        if (got.wbk_tot !== exp_res.wbk_tot)
                            $error("total_writebacks exp %0h got %0h",
                                   exp_res.wbk_tot, got.wbk_tot);
                        if (got !== exp_res) errors++;
                    end
                end
            end
        join_any

        wait_cnt = 0;
        while (pending_res.size() != 0 && wait_cnt < 200_000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_res.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
